// ===== sv/wsm_pkg.sv =====
package wsm_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    localparam logic [7:0] STAR_BYTE  = 8'h2A;
    localparam logic [7:0] QMARK_BYTE = 8'h3F;

    typedef enum logic [1:0] {
        MODE_NEW     = 2'd0,
        MODE_APPEND  = 2'd1,
        MODE_SUBJECT = 2'd2,
        MODE_END     = 2'd3
    } t_mode;

    typedef logic [PATTERN_MAX-1:0]      t_row;
    typedef logic [PATTERN_MAX-1:0][7:0] t_pat_bytes;

    // Pattern store view handed to the datapath
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             overflow;
        t_row             valid_mask;
        t_row             init_row;
    } t_pat_status;

endpackage

// ===== sv/wsm_pattern_store.sv =====
module wsm_pattern_store (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_commit,
    input  wsm_pkg::t_mode     i_mode,
    input  logic [7:0]         i_byte_value,
    output wsm_pkg::t_pat_bytes o_bytes,
    output wsm_pkg::t_pat_status o_status
);

    wsm_pkg::t_pat_bytes         r_bytes;
    logic [wsm_pkg::LEN_W-1:0]   r_len;
    logic                        r_overflow;
    wsm_pkg::t_row               r_valid;
    wsm_pkg::t_row               r_star;

    logic                        room;
    logic [wsm_pkg::IDX_W-1:0]   wr_idx;
    logic [wsm_pkg::IDX_W-1:0]   prev_idx;
    logic                        prev_star;
    logic                        do_write;

    assign room     = (r_len < wsm_pkg::LEN_W'(wsm_pkg::PATTERN_MAX));
    assign wr_idx   = r_len[wsm_pkg::IDX_W-1:0];
    assign prev_idx = wsm_pkg::IDX_W'(r_len - wsm_pkg::LEN_W'(1));
    // initial row bit j: pattern bytes 0..j are all stars
    assign prev_star = (r_len == '0) ? 1'b1 : r_star[prev_idx];
    assign do_write  = i_commit && (i_mode == wsm_pkg::MODE_APPEND) && room;

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_bytes[wr_idx] <= i_byte_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_overflow <= 1'b0;
            r_valid    <= '0;
            r_star     <= '0;
        end else if (i_commit) begin
            if (i_mode == wsm_pkg::MODE_NEW) begin
                r_len      <= '0;
                r_overflow <= 1'b0;
                r_valid    <= '0;
                r_star     <= '0;
            end else if (i_mode == wsm_pkg::MODE_APPEND) begin
                if (room) begin
                    r_len           <= r_len + wsm_pkg::LEN_W'(1);
                    r_valid[wr_idx] <= 1'b1;
                    r_star[wr_idx]  <= prev_star && (i_byte_value == wsm_pkg::STAR_BYTE);
                end else begin
                    r_overflow <= 1'b1;
                end
            end
        end
    end

    assign o_bytes             = r_bytes;
    assign o_status.len        = r_len;
    assign o_status.overflow   = r_overflow;
    assign o_status.valid_mask = r_valid;
    assign o_status.init_row   = r_star;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= wsm_pkg::LEN_W'(wsm_pkg::PATTERN_MAX))
        else $error("pattern length beyond capacity");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |-> (r_len == wsm_pkg::LEN_W'(wsm_pkg::PATTERN_MAX)))
        else $error("overflow flag set with room left");

    a_mask_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_len))
        else $error("valid mask out of step with length");

    a_star_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_star & ~r_valid) == '0)
        else $error("initial row bit beyond pattern length");

endmodule

// ===== sv/wsm_row_update.sv =====
module wsm_row_update (
    input  wsm_pkg::t_pat_bytes i_bytes,
    input  wsm_pkg::t_row       i_valid_mask,
    input  wsm_pkg::t_row       i_row,
    input  logic                i_empty,
    input  logic [7:0]          i_subject,
    output wsm_pkg::t_row       o_row
);

    wsm_pkg::t_row gen;
    wsm_pkg::t_row prop;
    wsm_pkg::t_row any;
    wsm_pkg::t_row sum;
    wsm_pkg::t_row carry;

    // Per lane: a literal or '?' takes the diagonal bit, a star keeps its
    // own bit (gen) and also passes a set bit from the lane below (prop).
    for (genvar j = 0; j < wsm_pkg::PATTERN_MAX; j++) begin : g_lane
        logic is_star;
        logic hit;
        logic diag;
        assign is_star = (i_bytes[j] == wsm_pkg::STAR_BYTE);
        assign hit     = (i_bytes[j] == wsm_pkg::QMARK_BYTE) || (i_bytes[j] == i_subject);
        if (j == 0) begin : g_first
            assign diag = i_empty;
        end else begin : g_rest
            assign diag = i_row[j-1];
        end
        assign gen[j]  = i_valid_mask[j] && (is_star ? i_row[j] : (hit && diag));
        assign prop[j] = i_valid_mask[j] && is_star;
    end

    // Star runs: carry chain of an add, the carry into each lane says a set
    // bit below reaches it through lanes that are set or are stars.
    assign any   = prop | gen;
    assign sum   = any + gen;
    assign carry = sum ^ any ^ gen;
    assign o_row = gen | (prop & carry);

endmodule

// ===== sv/wildcard_string_matcher_unit.sv =====
// Glob matcher, '*' for any run of bytes and '?' for one byte. Each input
// transaction carries a mode: new pattern, append pattern byte, subject byte,
// or end of subject; only end of subject yields an output transaction with
// the match bit and the pattern overflow flag (pattern bytes past 64 are
// dropped). Any pattern transaction restarts the subject. One transaction is
// taken every cycle; a result is registered in the output register after its
// end-of-subject transaction has passed the input register, and the input
// stalls only when an end of subject meets a result register that is still
// full. The cycle time is set by the row update: a compare per pattern
// position followed by one 64-bit add that carries star runs.
module wildcard_string_matcher_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_byte_value,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_matched,
    output logic       o_pattern_overflow
);

    logic                  r_in_valid;
    wsm_pkg::t_mode        r_in_mode;
    logic [7:0]            r_in_byte;

    wsm_pkg::t_row         r_row;
    logic                  r_empty;

    logic                  r_out_valid;
    logic                  r_matched;
    logic                  r_ovf;

    wsm_pkg::t_pat_bytes   pat_bytes;
    wsm_pkg::t_pat_status  pat;
    wsm_pkg::t_row         cur_row;
    wsm_pkg::t_row         n_row;
    logic                  advance;
    logic                  commit;
    logic                  accept;
    logic                  n_matched;
    logic [wsm_pkg::IDX_W-1:0] last_idx;

    assign advance = !((r_in_mode == wsm_pkg::MODE_END) && r_out_valid && !i_ready);
    assign commit  = r_in_valid && advance;
    assign o_ready = !r_in_valid || advance;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_in_mode  <= wsm_pkg::MODE_NEW;
        end else if (accept) begin
            r_in_valid <= 1'b1;
            r_in_mode  <= wsm_pkg::t_mode'(i_mode);
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_byte_value;
        end
    end

    wsm_pattern_store u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_commit     (commit),
        .i_mode       (r_in_mode),
        .i_byte_value (r_in_byte),
        .o_bytes      (pat_bytes),
        .o_status     (pat)
    );

    // Right after a restart the row is the all-star prefix of the pattern
    assign cur_row = r_empty ? pat.init_row : r_row;

    wsm_row_update u_row (
        .i_bytes      (pat_bytes),
        .i_valid_mask (pat.valid_mask),
        .i_row        (cur_row),
        .i_empty      (r_empty),
        .i_subject    (r_in_byte),
        .o_row        (n_row)
    );

    assign last_idx  = wsm_pkg::IDX_W'(pat.len - wsm_pkg::LEN_W'(1));
    assign n_matched = (pat.len == '0) ? r_empty : cur_row[last_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_empty <= 1'b1;
        end else if (commit) begin
            if (r_in_mode == wsm_pkg::MODE_SUBJECT) begin
                r_row   <= n_row;
                r_empty <= 1'b0;
            end else begin
                r_empty <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit && (r_in_mode == wsm_pkg::MODE_END)) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit && (r_in_mode == wsm_pkg::MODE_END)) begin
            r_matched <= n_matched;
            r_ovf     <= pat.overflow;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_matched          = r_matched;
    assign o_pattern_overflow = r_ovf;

    a_row_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_empty |-> ((r_row & ~pat.valid_mask) == '0))
        else $error("match row bit beyond pattern length");

    a_end_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && (r_in_mode == wsm_pkg::MODE_END)))
        else $error("blocked end-of-subject transaction lost");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_matched) && $stable(o_pattern_overflow)))
        else $error("output transaction dropped or changed while waiting");

endmodule

// ===== bench/wildcard_string_matcher_unit_tb.sv =====
module wildcard_string_matcher_unit_tb;

    localparam int          ITEM_TARGET = 1150;
    localparam int          STALL_LIMIT = 2000;
    localparam int          LONG_HOLD   = 150;
    localparam int          HOLD_AT     = 40;
    localparam logic [7:0]  LETTER_A    = 8'h61;
    localparam logic [7:0]  LETTER_B    = 8'h62;

    typedef struct packed {
        logic matched;
        logic overflow;
    } t_verdict;

    // Tracks the glob state and holds the verdicts still owed by the block.
    class glob_scoreboard;
        logic [7:0]     pat_mem [wsm_pkg::PATTERN_MAX];
        int             pat_len;
        logic           empty_hit;
        wsm_pkg::t_row  prefix_hits;
        logic           dropped;
        t_verdict       verdict_q[$];
        int             errors;

        function new();
            pat_len     = 0;
            empty_hit   = 1'b1;
            prefix_hits = '0;
            dropped     = 1'b0;
            errors      = 0;
        endfunction

        // Empty subject: a prefix matches only if it is all stars.
        function void restart_subject();
            logic prev;
            int   j;
            prev        = 1'b1;
            prefix_hits = '0;
            for (j = 0; j < pat_len; j++) begin
                prev           = (pat_mem[j] == wsm_pkg::STAR_BYTE) ? prev : 1'b0;
                prefix_hits[j] = prev;
            end
            empty_hit = 1'b1;
        endfunction

        function void consume_byte(logic [7:0] ch);
            logic new_prev, old_prev, old_here, hit;
            wsm_pkg::t_row nxt;
            int   j;
            new_prev = 1'b0;
            old_prev = empty_hit;
            nxt      = '0;
            for (j = 0; j < pat_len; j++) begin
                old_here = prefix_hits[j];
                if (pat_mem[j] == wsm_pkg::STAR_BYTE)
                    hit = new_prev | old_here;
                else if (pat_mem[j] == wsm_pkg::QMARK_BYTE || pat_mem[j] == ch)
                    hit = old_prev;
                else
                    hit = 1'b0;
                nxt[j]   = hit;
                new_prev = hit;
                old_prev = old_here;
            end
            empty_hit   = 1'b0;
            prefix_hits = nxt;
        endfunction

        function void note_item(wsm_pkg::t_mode m, logic [7:0] b);
            t_verdict v;
            case (m)
                wsm_pkg::MODE_NEW: begin
                    pat_len = 0;
                    dropped = 1'b0;
                    restart_subject();
                end
                wsm_pkg::MODE_APPEND: begin
                    if (pat_len < wsm_pkg::PATTERN_MAX) begin
                        pat_mem[pat_len] = b;
                        pat_len++;
                    end else begin
                        dropped = 1'b1;
                    end
                    restart_subject();
                end
                wsm_pkg::MODE_SUBJECT: consume_byte(b);
                default: begin
                    v.matched  = (pat_len == 0) ? empty_hit : prefix_hits[pat_len-1];
                    v.overflow = dropped;
                    verdict_q  = {verdict_q, v};
                    restart_subject();
                end
            endcase
        endfunction

        function void check_verdict(logic matched, logic overflow);
            t_verdict v;
            if (verdict_q.size() == 0) begin
                $error("result with no transaction pending: matched %0b overflow %0b",
                       matched, overflow);
                errors++;
                return;
            end
            v = verdict_q.pop_front();
            if (matched !== v.matched) begin
                $error("matched: expected %0b, got %0b", v.matched, matched);
                errors++;
            end
            if (overflow !== v.overflow) begin
                $error("pattern_overflow: expected %0b, got %0b", v.overflow, overflow);
                errors++;
            end
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [1:0] i_mode       = wsm_pkg::MODE_NEW;
    logic [7:0] i_byte_value = 8'h00;
    logic       i_ready      = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic       o_matched;
    logic       o_pattern_overflow;

    glob_scoreboard sb = new();
    logic [7:0]     cur_glob[$];
    int             items_sent   = 0;
    int             results_seen = 0;
    int             idle_cycles  = 0;
    int             send_calm    = 0;

    wildcard_string_matcher_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_mode             (i_mode),
        .i_byte_value       (i_byte_value),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_matched          (o_matched),
        .o_pattern_overflow (o_pattern_overflow)
    );

    always #5 i_clk = ~i_clk;

    // Called and returning at a falling edge; valid stays up after a
    // transaction so back-to-back items need no second assignment.
    task automatic send_item(input wsm_pkg::t_mode m, input logic [7:0] b);
        int gap;
        if (send_calm > 0) begin
            gap = 0;
            send_calm--;
        end else begin
            gap = $urandom_range(0, 4);
            if ($urandom_range(0, 30) == 0)
                send_calm = 40;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_mode       <= m;
        i_byte_value <= b;
        do @(posedge i_clk); while (!o_ready);
        sb.note_item(m, b);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] glob_byte();
        case ($urandom_range(0, 7))
            0, 1:    return wsm_pkg::STAR_BYTE;
            2:       return wsm_pkg::QMARK_BYTE;
            3, 4:    return LETTER_A;
            5:       return LETTER_B;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] text_byte();
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return LETTER_A;
            4, 5:       return LETTER_B;
            default:    return 8'($urandom);
        endcase
    endfunction

    task automatic load_glob(input int len);
        logic [7:0] b;
        cur_glob.delete();
        send_item(wsm_pkg::MODE_NEW, 8'($urandom));
        repeat (len) begin
            b = glob_byte();
            cur_glob = {cur_glob, b};
            send_item(wsm_pkg::MODE_APPEND, b);
        end
    endtask

    // A conforming subject is built from the stored part of the glob.
    task automatic send_subject(input bit conforming);
        logic [7:0] text[$];
        int         n;
        int         k;
        if (conforming) begin
            n = (cur_glob.size() > wsm_pkg::PATTERN_MAX) ? wsm_pkg::PATTERN_MAX
                                                         : cur_glob.size();
            for (k = 0; k < n; k++) begin
                if (cur_glob[k] == wsm_pkg::STAR_BYTE)
                    repeat ($urandom_range(0, 3)) text = {text, text_byte()};
                else if (cur_glob[k] == wsm_pkg::QMARK_BYTE)
                    text = {text, 8'($urandom)};
                else
                    text = {text, cur_glob[k]};
            end
        end else begin
            repeat ($urandom_range(0, 8)) text = {text, text_byte()};
        end
        for (k = 0; k < text.size(); k++)
            send_item(wsm_pkg::MODE_SUBJECT, text[k]);
        send_item(wsm_pkg::MODE_END, 8'($urandom));
    endtask

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("wildcard_string_matcher_unit: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side
    initial begin
        int stall;
        int calm_left;
        calm_left = 0;
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            if (results_seen == HOLD_AT) begin
                stall = LONG_HOLD;
            end else if (calm_left > 0) begin
                stall = 0;
                calm_left--;
            end else begin
                stall = $urandom_range(0, 4);
                if ($urandom_range(0, 30) == 0)
                    calm_left = 30;
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            sb.check_verdict(o_matched, o_pattern_overflow);
            results_seen++;
            @(negedge i_clk);
        end
    end

    // Input side
    initial begin
        int  seq;
        int  len;
        bit  drained_mid;
        seq         = 0;
        drained_mid = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty pattern against empty and nonempty subjects
        send_item(wsm_pkg::MODE_END, 8'h00);
        send_item(wsm_pkg::MODE_SUBJECT, 8'h00);
        send_item(wsm_pkg::MODE_END, 8'hFF);
        // lone star: matches empty and one-byte subjects
        send_item(wsm_pkg::MODE_APPEND, wsm_pkg::STAR_BYTE);
        send_item(wsm_pkg::MODE_END, 8'h00);
        send_item(wsm_pkg::MODE_SUBJECT, 8'hFF);
        send_item(wsm_pkg::MODE_END, 8'h00);
        // "?" then a zero byte
        send_item(wsm_pkg::MODE_NEW, 8'hFF);
        send_item(wsm_pkg::MODE_APPEND, wsm_pkg::QMARK_BYTE);
        send_item(wsm_pkg::MODE_APPEND, 8'h00);
        send_item(wsm_pkg::MODE_SUBJECT, 8'h80);
        send_item(wsm_pkg::MODE_SUBJECT, 8'h00);
        send_item(wsm_pkg::MODE_END, 8'h55);
        send_item(wsm_pkg::MODE_SUBJECT, 8'h00);
        send_item(wsm_pkg::MODE_END, 8'hAA);
        // star chain in the middle; an append mid-subject restarts it
        send_item(wsm_pkg::MODE_NEW, 8'h00);
        send_item(wsm_pkg::MODE_APPEND, LETTER_A);
        send_item(wsm_pkg::MODE_APPEND, wsm_pkg::STAR_BYTE);
        send_item(wsm_pkg::MODE_APPEND, wsm_pkg::STAR_BYTE);
        send_item(wsm_pkg::MODE_APPEND, LETTER_B);
        send_item(wsm_pkg::MODE_SUBJECT, LETTER_A);
        send_item(wsm_pkg::MODE_SUBJECT, LETTER_B);
        send_item(wsm_pkg::MODE_END, 8'h00);
        send_item(wsm_pkg::MODE_SUBJECT, LETTER_A);
        send_item(wsm_pkg::MODE_APPEND, 8'h63);
        send_item(wsm_pkg::MODE_END, 8'h00);
        wait_for_results();

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 4) != 0) begin
                // long globs around the capacity edge, mostly short ones
                len = (seq % 40 == 0) ? $urandom_range(63, 68) : $urandom_range(0, 8);
                load_glob(len);
                repeat ($urandom_range(1, 4)) send_subject($urandom_range(0, 1));
                seq++;
            end else begin
                repeat ($urandom_range(1, 6))
                    send_item(wsm_pkg::t_mode'($urandom_range(0, 3)), 8'($urandom));
            end
            if (!drained_mid && items_sent >= ITEM_TARGET / 2) begin
                wait_for_results();
                drained_mid = 1'b1;
            end
        end

        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("wildcard_string_matcher_unit: match");
        else
            $display("wildcard_string_matcher_unit: mismatch");
        $finish;
    end

endmodule
